// ===== rtl/spq_pkg.sv =====
// Shared types, constants and table functions for the scale pitch quantizer.
package spq_pkg;

  localparam int SCALE_COUNT = 42;

  localparam logic [22:0] BAND_LOW_Q8     = 23'd5120;
  localparam logic [22:0] BAND_HIGH_Q8    = 23'd5120000;
  localparam logic [23:0] NOTE_OFFSET_Q16 = 24'd2383958;

  localparam logic REG_ROOT  = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  // Bit 11 is scale degree 0.
  localparam logic [11:0] SCALE_ROM [SCALE_COUNT] = '{
    12'b101011010101, 12'b101101010110, 12'b110101011010, 12'b101010110101,
    12'b101011010110, 12'b101101011010, 12'b110101101010,
    12'b101101011001, 12'b101101010101, 12'b101011011001, 12'b101100111001,
    12'b110101011001, 12'b110101010101,
    12'b101010010100, 12'b100101010010, 12'b100101110010, 12'b101110010100,
    12'b101011010111, 12'b101011011101, 12'b110110101010, 12'b101010110110,
    12'b110110110110, 12'b101101101101, 12'b100110011001,
    12'b110011011001, 12'b110011011010, 12'b110011011001, 12'b110011101001,
    12'b101100011000, 12'b110001010010, 12'b110001100010, 12'b101100010100,
    12'b110100011000,
    12'b110100111001, 12'b110010110101, 12'b110010111001,
    12'b101001010010,
    12'b101010101010, 12'b101010100110, 12'b110010110010, 12'b110010101011,
    12'b111111111111
  };

  typedef struct packed {
    logic [7:0] note;
    logic [8:0] tone_dist;
  } match_t;

  // log2(1 + idx/2^bits) in Q0.16 by repeated squaring; elaboration only.
  function automatic logic [15:0] log_mantissa(input int idx, input int bits);
    logic [63:0] x;
    logic [15:0] r;
    x = (64'(1 << bits) + 64'(idx)) << (30 - bits);
    r = '0;
    for (int k = 15; k >= 0; k--) begin
      x = (x * x) >> 30;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/spq_log.sv =====
// Leading-one detect, band check and log2 mantissa lookup.
module spq_log #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic [22:0] frequency_q8,
  output logic        in_band,
  output logic [4:0]  msb_pos,
  output logic [15:0] mant
);

  localparam int TABLE_SIZE = 1 << LOG_TABLE_BITS;

  logic [15:0] log_rom [TABLE_SIZE];
  logic [4:0]  shift_amt;
  logic [22:0] shifted;
  logic [LOG_TABLE_BITS-1:0] idx;

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_rom
    assign log_rom[i] = spq_pkg::log_mantissa(i, LOG_TABLE_BITS);
  end

  always_comb begin
    msb_pos = '0;
    for (int i = 1; i < 23; i++) begin
      if (frequency_q8[i]) msb_pos = 5'(i);
    end
  end

  assign in_band   = (frequency_q8 >= spq_pkg::BAND_LOW_Q8) &&
                     (frequency_q8 <= spq_pkg::BAND_HIGH_Q8);
  assign shift_amt = msb_pos - 5'(LOG_TABLE_BITS);
  assign shifted   = frequency_q8 >> shift_amt;
  assign idx       = shifted[LOG_TABLE_BITS-1:0];
  assign mant      = log_rom[idx];

endmodule

// ===== rtl/spq_match.sv =====
// Nearest in-scale note search and circular distance to the scale.
module spq_match #(
  parameter int NOTE_FRAC_BITS = 8
) (
  input  logic [NOTE_FRAC_BITS+7:0] note_q,
  input  logic [11:0]               tone_mask,
  output spq_pkg::match_t           result
);

  localparam int QW = NOTE_FRAC_BITS + 8;
  localparam logic [NOTE_FRAC_BITS:0] UNIT = {1'b1, {NOTE_FRAC_BITS{1'b0}}};
  localparam logic [QW:0] HALF = (QW + 1)'(1) << (NOTE_FRAC_BITS - 1);

  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  base;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd171;
    base = 8'(prod[15:11]) * 8'd12;
    rem  = v - base;
    return rem[3:0];
  endfunction

  logic [QW:0]   round_sum;
  logic [7:0]    near;
  logic [3:0]    near_pc;
  logic          below;
  logic [23:0]   mask2;
  logic [23:0]   mask_rot;
  logic [11:0]   rr;
  logic          hit;
  logic [2:0]    k_sel;
  logic          up_sel;
  logic          dn_sel;
  logic [7:0]    int_part;
  logic [3:0]    cur_pc;
  logic [3:0]    next_pc;
  logic [NOTE_FRAC_BITS-1:0] frac;
  logic [NOTE_FRAC_BITS:0]   d_cur;
  logic [NOTE_FRAC_BITS:0]   d_next;
  logic [NOTE_FRAC_BITS:0]   d_min;
  logic [8:0]    dist_q8;
  logic          empty;

  assign empty     = (tone_mask == '0);
  assign round_sum = (QW + 1)'(note_q) + HALF;
  assign near      = round_sum[NOTE_FRAC_BITS +: 8];
  assign below     = note_q[NOTE_FRAC_BITS-1];
  assign near_pc   = mod12(near);
  assign mask2     = {tone_mask, tone_mask};
  assign mask_rot  = mask2 >> near_pc;
  assign rr        = mask_rot[11:0];

  // rr[i] marks pitch class of near + i
  always_comb begin
    hit    = 1'b0;
    k_sel  = '0;
    up_sel = 1'b0;
    dn_sel = 1'b0;
    for (int k = 6; k >= 0; k--) begin
      if (rr[k] || rr[(12 - k) % 12]) begin
        hit    = 1'b1;
        k_sel  = 3'(k);
        up_sel = rr[k];
        dn_sel = rr[(12 - k) % 12];
      end
    end
  end

  assign int_part = note_q[NOTE_FRAC_BITS +: 8];
  assign frac     = note_q[NOTE_FRAC_BITS-1:0];
  assign cur_pc   = mod12(int_part);
  assign next_pc  = (cur_pc == 4'd11) ? 4'd0 : cur_pc + 4'd1;
  assign d_cur    = tone_mask[cur_pc] ? {1'b0, frac} : UNIT;
  assign d_next   = tone_mask[next_pc] ? UNIT - {1'b0, frac} : UNIT;
  assign d_min    = (d_cur < d_next) ? d_cur : d_next;

  if (NOTE_FRAC_BITS > 8) begin : g_round
    localparam int SH = NOTE_FRAC_BITS - 8;
    logic [NOTE_FRAC_BITS:0] dsum;
    assign dsum    = d_min + (NOTE_FRAC_BITS + 1)'(1 << (SH - 1));
    assign dist_q8 = dsum[SH +: 9];
  end else if (NOTE_FRAC_BITS == 8) begin : g_same
    assign dist_q8 = d_min;
  end else begin : g_widen
    assign dist_q8 = {d_min, {(8 - NOTE_FRAC_BITS){1'b0}}};
  end

  always_comb begin
    result.note      = '0;
    result.tone_dist = '0;
    if (!empty && hit) begin
      if (k_sel == 3'd0) begin
        result.note = near;
      end else if (up_sel && (!dn_sel || !below)) begin
        result.note = near + 8'(k_sel);
      end else begin
        result.note = near - 8'(k_sel);
      end
    end
    if (!empty) result.tone_dist = dist_q8;
  end

endmodule

// ===== rtl/scale_pitch_quantizer.sv =====
// Top level: frequency to nearest scale note and tonal distance, three-stage pipeline.
// Takes one frequency per clock while in_stall is low and returns one result per frequency,
// in order, through the log lookup, note format and scale match registers.
// Throughput is one beat per cycle while out_stall is low; each of the three
// pipeline registers (log lookup, note format, scale match) loads when it is empty or
// the next stage moves, so a stalled result still lets new beats fill empty stages.
// Configuration writes are always ready; the scale settings are applied in the
// match stage, so write them only while no beat is in flight.
module scale_pitch_quantizer #(
  parameter int LOG_TABLE_BITS = 8,
  parameter int NOTE_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [22:0] frequency_q8,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        in_range,
  output logic [7:0]  nearest_note,
  output logic [8:0]  tonal_distance_q8,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int QW = NOTE_FRAC_BITS + 8;
  localparam logic [24:0] Q_HALF = 25'(1) << (15 - NOTE_FRAC_BITS);

  logic [3:0]  root_pitch_class;
  logic [5:0]  scale_select;

  logic        a_valid;
  logic        a_in_range;
  logic [4:0]  a_msb_pos;
  logic [15:0] a_mant;
  logic        b_valid;
  logic        b_in_range;
  logic [QW-1:0] b_note_q;

  logic        adv_out;
  logic        adv_b;
  logic        adv_a;

  logic        log_in_band;
  logic [4:0]  log_msb_pos;
  logic [15:0] log_mant;

  logic [4:0]  exp_off;
  logic [19:0] l2;
  logic [23:0] nq16;
  logic [24:0] q_sum;
  logic [QW-1:0] note_q;

  logic [3:0]  root_mod;
  logic [11:0] scale_bits;
  logic [11:0] tone_mask;
  spq_pkg::match_t match;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_pitch_class <= '0;
      scale_select     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spq_pkg::REG_ROOT:  root_pitch_class <= cfg_data[3:0];
        spq_pkg::REG_SCALE: scale_select     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv_out  = !out_valid || !out_stall;
  assign adv_b    = !b_valid || adv_out;
  assign adv_a    = !a_valid || adv_b;
  assign in_stall = !adv_a;

  spq_log #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_log (
    .frequency_q8(frequency_q8),
    .in_band     (log_in_band),
    .msb_pos     (log_msb_pos),
    .mant        (log_mant)
  );

  // note = 12*log2(f) - offset, then rounded to NOTE_FRAC_BITS
  assign exp_off = a_msb_pos - 5'd8;
  assign l2      = {exp_off[3:0], a_mant};
  assign nq16    = 24'({l2, 3'b000}) + 24'({l2, 2'b00}) - spq_pkg::NOTE_OFFSET_Q16;
  assign q_sum   = 25'(nq16) + Q_HALF;
  assign note_q  = q_sum[16 - NOTE_FRAC_BITS +: QW];

  assign root_mod   = (root_pitch_class >= 4'd12) ? root_pitch_class - 4'd12
                                                  : root_pitch_class;
  assign scale_bits = (scale_select < 6'(spq_pkg::SCALE_COUNT))
                      ? spq_pkg::SCALE_ROM[scale_select] : 12'd0;

  always_comb begin
    logic [4:0] rel;
    for (int pc = 0; pc < 12; pc++) begin
      rel = 5'(pc) + 5'd12 - 5'(root_mod);
      if (rel >= 5'd12) rel = rel - 5'd12;
      tone_mask[pc] = scale_bits[4'd11 - rel[3:0]];
    end
  end

  spq_match #(
    .NOTE_FRAC_BITS(NOTE_FRAC_BITS)
  ) u_match (
    .note_q   (b_note_q),
    .tone_mask(tone_mask),
    .result   (match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a)   a_valid   <= in_valid;
      if (adv_b)   b_valid   <= a_valid;
      if (adv_out) out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_in_range <= log_in_band;
      a_msb_pos  <= log_msb_pos;
      a_mant     <= log_mant;
    end
    if (adv_b) begin
      b_in_range <= a_in_range;
      b_note_q   <= note_q;
    end
    if (adv_out) begin
      in_range          <= b_in_range;
      nearest_note      <= b_in_range ? match.note : 8'd0;
      tonal_distance_q8 <= b_in_range ? match.tone_dist : 9'd0;
    end
  end

`ifndef SYNTHESIS
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> a_valid)
    else $error("accepted beat did not enter first stage");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> a_valid && b_valid && out_valid)
    else $error("input stalled with an empty pipeline stage");

  a_out_band_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> nearest_note == 8'd0 && tonal_distance_q8 == 9'd0)
    else $error("out of band result not zero");

  a_dist_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tonal_distance_q8 <= 9'd256)
    else $error("tonal distance above one semitone");
`endif

endmodule

// ===== test/pitch_checker.sv =====
// Scoreboard: predicts note, in-band flag and tonal distance per frequency beat and checks results.
module pitch_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [22:0] frequency_q8,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        in_range,
  input  logic [7:0]  nearest_note,
  input  logic [8:0]  tonal_distance_q8,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  output int          pending,
  output int          fails
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [22:0] LOW_EDGE_Q8  = 23'd5120;
  localparam logic [22:0] HIGH_EDGE_Q8 = 23'd5120000;
  localparam longint A4_OFFSET_Q16 = 2383958;
  localparam int MODE_COUNT = 42;

  // Scale degree 0 in the top bit of each entry, entry 0 first.
  localparam logic [MODE_COUNT*12-1:0] MODE_MASKS = {
    12'b101011010101, 12'b101101010110, 12'b110101011010, 12'b101010110101,
    12'b101011010110, 12'b101101011010, 12'b110101101010,
    12'b101101011001, 12'b101101010101, 12'b101011011001, 12'b101100111001,
    12'b110101011001, 12'b110101010101,
    12'b101010010100, 12'b100101010010, 12'b100101110010, 12'b101110010100,
    12'b101011010111, 12'b101011011101, 12'b110110101010, 12'b101010110110,
    12'b110110110110, 12'b101101101101, 12'b100110011001,
    12'b110011011001, 12'b110011011010, 12'b110011011001, 12'b110011101001,
    12'b101100011000, 12'b110001010010, 12'b110001100010, 12'b101100010100,
    12'b110100011000,
    12'b110100111001, 12'b110010110101, 12'b110010111001,
    12'b101001010010,
    12'b101010101010, 12'b101010100110, 12'b110010110010, 12'b110010101011,
    12'b111111111111
  };

  typedef struct packed {
    logic        in_band;
    logic [7:0]  note;
    logic [8:0]  tone_dist;
    logic [22:0] freq;
  } pitch_result_t;

  pitch_result_t expected_pitches[$];
  pitch_result_t head;
  logic [15:0]   log2_frac [256];
  logic [3:0]    root_pc;
  logic [5:0]    scale_sel;

  initial begin
    logic [63:0] acc;
    for (int i = 0; i < 256; i++) begin
      acc = (64'd256 + 64'(i)) << 22;
      log2_frac[i] = '0;
      for (int k = 15; k >= 0; k--) begin
        acc = (acc * acc) >> 30;
        if (acc >= 64'h8000_0000) begin
          acc = acc >> 1;
          log2_frac[i][k] = 1'b1;
        end
      end
    end
  end

  function automatic bit tone_on(input int pc);
    logic [11:0] m;
    int rel;
    if (scale_sel >= MODE_COUNT) return 1'b0;
    m = MODE_MASKS[(MODE_COUNT - 1 - int'(scale_sel)) * 12 +: 12];
    rel = (pc - int'(root_pc) % 12 + 24) % 12;
    return m[11 - rel];
  endfunction

  function automatic pitch_result_t classify_freq(input logic [22:0] f);
    pitch_result_t r;
    int p;
    logic [7:0] idx;
    longint lg, q, rn, best_d, best_n, pcq, min_d, d, cand;
    bit any;
    r = '0;
    r.freq = f;
    if (f < LOW_EDGE_Q8 || f > HIGH_EDGE_Q8) return r;
    p = 22;
    while (p > 0 && !f[p]) p--;
    idx = 8'(f >> (p - 8));
    lg = longint'(p - 8) * 65536 + longint'(log2_frac[idx]);
    q = (12 * lg - A4_OFFSET_Q16 + 128) >>> 8;
    rn = (q + 128) >>> 8;
    best_n = 0;
    best_d = 100 * 256;
    for (int off = 0; off <= 6; off++) begin
      for (int side = 0; side < ((off > 0) ? 2 : 1); side++) begin
        cand = (side == 0) ? rn + off : rn - off;
        if (tone_on(int'(((cand % 12) + 12) % 12))) begin
          d = q - cand * 256;
          if (d < 0) d = -d;
          if (d < best_d) begin
            best_d = d;
            best_n = cand;
          end
        end
      end
    end
    pcq = q % 3072;
    if (pcq < 0) pcq += 3072;
    min_d = 3072;
    any = 1'b0;
    for (int s = 0; s < 12; s++) begin
      if (tone_on(s)) begin
        any = 1'b1;
        d = pcq - s * 256;
        if (d < 0) d = -d;
        if (3072 - d < d) d = 3072 - d;
        if (d < min_d) min_d = d;
      end
    end
    r.in_band = 1'b1;
    r.note = 8'(best_n);
    r.tone_dist = any ? 9'((min_d > 256) ? 256 : min_d) : 9'd0;
    return r;
  endfunction

  task automatic report(input string what, input int freq, input int got, input int want);
    fails++;
    $display("mismatch %s: freq_q8 %0d got %0d want %0d", what, freq, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      root_pc = '0;
      scale_sel = '0;
      fails = 0;
      expected_pitches.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == spq_pkg::REG_ROOT) root_pc = cfg_data[3:0];
        else scale_sel = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_pitches.size() == 0) begin
          report("unexpected result beat", -1, int'(nearest_note), -1);
        end else begin
          head = expected_pitches.pop_front();
          if (in_range !== head.in_band)
            report("in_range", int'(head.freq), int'(in_range), int'(head.in_band));
          if (nearest_note !== head.note)
            report("nearest_note", int'(head.freq), int'(nearest_note), int'(head.note));
          if (tonal_distance_q8 !== head.tone_dist)
            report("tonal_distance_q8", int'(head.freq), int'(tonal_distance_q8),
                   int'(head.tone_dist));
        end
      end
      if (in_valid && !in_stall) expected_pitches.push_back(classify_freq(frequency_q8));
    end
    pending <= expected_pitches.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the quantizer testbench: clock, reset, scale settings and frequency stimulus.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [22:0] frequency_q8;
  logic        out_valid;
  logic        out_stall;
  logic        in_range;
  logic [7:0]  nearest_note;
  logic [8:0]  tonal_distance_q8;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [5:0]  cfg_data;
  int          pending;
  int          fails;
  bit          tx_calm;
  bit          rx_calm;
  int          hold_reqs;

  scale_pitch_quantizer dut (.*);
  pitch_checker chk (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [22:0] rand_freq();
    int r, p;
    logic [22:0] f;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      // log-spread over the audio band so every octave gets its share
      do begin
        p = $urandom_range(12, 22);
        f = 23'($urandom) & ((23'd1 << p) - 23'd1);
        f[p] = 1'b1;
      end while (f < 23'd5120 || f > 23'd5120000);
    end else if (r < 87) begin
      f = (r[0] ? 23'd5120 : 23'd5120000) + 23'($urandom_range(0, 6)) - 23'd3;
    end else begin
      f = 23'($urandom);
    end
    return f;
  endfunction

  // receiver back-pressure
  initial begin
    int stall_left, run_left, holds_seen;
    out_stall = 1'b0;
    stall_left = 0;
    run_left = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        stall_left = 80;
      end else if (stall_left == 0 && run_left == 0) begin
        stall_left = rx_calm ? 0 : gap_len();
        run_left = $urandom_range(1, 24);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (run_left > 0) run_left--;
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_freq(input logic [22:0] f);
    int gap;
    in_valid <= 1'b1;
    frequency_q8 <= f;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = tx_calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_corners();
    send_freq(23'd0);       send_freq(23'd1);       send_freq(23'd5119);
    send_freq(23'd5120);    send_freq(23'd5121);    send_freq(23'd65535);
    send_freq(23'd66977);   send_freq(23'd112640);  send_freq(23'd112768);
    send_freq(23'd115940);  send_freq(23'd256000);  send_freq(23'd2796202);
    send_freq(23'd4194303); send_freq(23'd4194304); send_freq(23'd5119999);
    send_freq(23'd5120000); send_freq(23'd5120001); send_freq(23'h7FFFFF);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_scale(input logic [5:0] root_data, input logic [5:0] scale_data);
    cfg_valid <= 1'b1;
    cfg_index <= spq_pkg::REG_ROOT;
    cfg_data <= root_data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= spq_pkg::REG_SCALE;
    cfg_data <= scale_data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [5:0] rd, sd;
    rst = 1'b1;
    in_valid = 1'b0;
    frequency_q8 = '0;
    cfg_valid = 1'b0;
    cfg_index = spq_pkg::REG_ROOT;
    cfg_data = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_reqs = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        0: ;
        1: set_scale(6'd11, 6'd41);
        2: set_scale(6'd63, 6'd63);
        3: set_scale(6'd0, 6'd42);
        4: set_scale(6'd12, 6'd0);
        default: begin
          rd = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 11));
          sd = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(42, 63))
                                           : 6'($urandom_range(0, 41));
          set_scale(rd, sd);
        end
      endcase
      tx_calm = (ph % 4 == 1) || (ph == 2);
      rx_calm = (ph % 4 == 1);
      if (ph < 5) send_corners();
      for (int n = 0; n < 52; n++) begin
        // long receiver hold while beats keep coming: pipeline fills, input stalls
        if (ph == 2 && n == 4) hold_reqs++;
        if (ph == 7 && n == 26) drain();
        send_freq(rand_freq());
      end
      drain();
    end
    repeat (12) @(negedge clk);
    if (fails == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
